/* src/lpr_pkg.sv */
package lpr_pkg;

  // sizing
  localparam int LPR_MAX_MESSAGE_BYTES = 2048;
  localparam int LPR_QUEUE_DEPTH       = 2;

  // header bit positions
  localparam int HB_DUMMY_BIT = 9;
  localparam int HB_FIRST_BIT = 8;
  localparam int HB_VALID_BIT = 7;
  localparam int HB_TYPE_BIT  = 6;
  localparam int HB_COUNT_MSB = 5;

  localparam logic [11:0] BASE_PAYLOAD   = 12'd32;
  localparam logic [7:0]  LOWEST_VERSION = 8'd2;

  // item kinds
  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_CFG_REQ  = 2'd1,
    KIND_XFER_ERR = 2'd2,
    KIND_DETACH   = 2'd3
  } kind_t;

  // ack classes
  localparam logic [1:0] ACK_REQUIRED = 2'd0;
  localparam logic [1:0] ACK_DUMMY    = 2'd1;
  localparam logic [1:0] ACK_GARBAGE  = 2'd2;
  localparam logic [1:0] ACK_NONE     = 2'd3;

  // drop codes
  localparam logic [2:0] DROP_NONE     = 3'd0;
  localparam logic [2:0] DROP_RESTART  = 3'd1;
  localparam logic [2:0] DROP_STRAY    = 3'd2;
  localparam logic [2:0] DROP_MISMATCH = 3'd3;
  localparam logic [2:0] DROP_OVERFLOW = 3'd4;

  // config request status
  localparam logic [1:0] CST_NONE   = 2'd0;
  localparam logic [1:0] CST_OK     = 2'd1;
  localparam logic [1:0] CST_UNSUPP = 2'd2;

  // register indexes
  localparam logic REG_DESIRED_PAYLOAD = 1'b0;
  localparam logic REG_ACK_ENABLE      = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  header_bits;
    logic        tx_queue_empty;
    logic [15:0] req_max_payload;
    logic [7:0]  req_features;
    logic [7:0]  req_version;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  ack_class;
    logic        store_payload;
    logic [10:0] write_offset;
    logic        deliver;
    logic [11:0] message_length;
    logic        message_type;
    logic [2:0]  drop_code;
    logic [11:0] payload_size;
    logic [1:0]  cfg_status;
    logic [11:0] resp_payload_size;
    logic        resp_ack_feature;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  ack_class;
    logic        first;
    logic        net_msg;
    logic [5:0]  count;
    logic        tx_empty;
    logic        ver_ok;
    logic        ack_req;
    logic [15:0] max_payload;
  } cmd_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* src/lpr_front.sv */
module lpr_front (
  input  lpr_pkg::in_item_t in_item,
  output lpr_pkg::cmd_t     cmd
);
  import lpr_pkg::*;

  logic valid_bit;
  logic dummy_bit;

  assign valid_bit = in_item.header_bits[HB_VALID_BIT];
  assign dummy_bit = in_item.header_bits[HB_DUMMY_BIT];

  // decode kind and classify the header
  always_comb begin
    cmd.kind        = kind_t'(in_item.kind);
    cmd.first       = in_item.header_bits[HB_FIRST_BIT];
    cmd.net_msg     = in_item.header_bits[HB_TYPE_BIT];
    cmd.count       = in_item.header_bits[HB_COUNT_MSB:0];
    cmd.tx_empty    = in_item.tx_queue_empty;
    cmd.ver_ok      = (in_item.req_version >= LOWEST_VERSION);
    cmd.ack_req     = in_item.req_features[0];
    cmd.max_payload = in_item.req_max_payload;
    if (valid_bit && !dummy_bit) begin
      cmd.ack_class = ACK_REQUIRED;
    end else if (dummy_bit && !valid_bit) begin
      cmd.ack_class = ACK_DUMMY;
    end else begin
      cmd.ack_class = ACK_GARBAGE;
    end
  end

endmodule

/* src/lpr_queue.sv */
module lpr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpr_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output lpr_pkg::cmd_t       pop_cmd,
  output lpr_pkg::q_status_t  status
);
  import lpr_pkg::*;

  localparam int PW = (LPR_QUEUE_DEPTH > 1) ? $clog2(LPR_QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(LPR_QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(LPR_QUEUE_DEPTH - 1);

  cmd_t          mem_r [LPR_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign status.full  = (count_r == CW'(LPR_QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_cmd      = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

/* src/lpr_back.sv */
module lpr_back #(
  parameter int MAX_MESSAGE_BYTES = lpr_pkg::LPR_MAX_MESSAGE_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [11:0]         cfg_wdata,
  input  logic                cmd_avail,
  input  lpr_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lpr_pkg::out_item_t  out_data
);
  import lpr_pkg::*;

  localparam int FW  = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CW  = ((FW > 12) ? FW : 12) + 1;
  localparam int NW  = (CW > 16) ? CW : 16;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_MESSAGE_BYTES);

  logic [11:0]   desired_r;
  logic          ack_en_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [5:0]    left_r, left_nxt;
  logic [11:0]   cur_r, cur_nxt;
  logic [11:0]   pend_r, pend_nxt;
  logic          out_valid_r;
  out_item_t     out_r, out_nxt;

  assign cmd_pop   = cmd_avail && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_r <= BASE_PAYLOAD;
      ack_en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DESIRED_PAYLOAD: desired_r <= cfg_wdata;
        REG_ACK_ENABLE:      ack_en_r  <= cfg_wdata[0];
        default:             ;
      endcase
    end
  end

  // execute one request
  always_comb begin
    logic          go;
    logic [FW-1:0] fill_v;
    logic [5:0]    left_v;
    logic [CW-1:0] sum_v;
    logic [CW-1:0] want_v;
    logic [NW-1:0] pl_v;

    fill_nxt = fill_r;
    left_nxt = left_r;
    cur_nxt  = cur_r;
    pend_nxt = pend_r;
    out_nxt  = '0;
    out_nxt.ack_class = ACK_NONE;
    go     = 1'b0;
    fill_v = fill_r;
    left_v = left_r;
    sum_v  = '0;
    want_v = '0;
    pl_v   = '0;

    case (cmd.kind)
      KIND_HEADER: begin
        out_nxt.ack_class = cmd.ack_class;
        if (cmd.ack_class != ACK_REQUIRED) begin
          // dummy or garbage: apply a pending size once tx is idle
          if (pend_r != '0 && cmd.tx_empty) begin
            cur_nxt  = pend_r;
            pend_nxt = '0;
          end
        end else if (CW'(desired_r) == MAX_C && CW'(cur_r) == MAX_C) begin
          // whole-message packets
          if (cmd.first) begin
            out_nxt.store_payload  = 1'b1;
            out_nxt.deliver        = 1'b1;
            out_nxt.message_length = cur_r;
            out_nxt.message_type   = cmd.net_msg;
          end else begin
            out_nxt.drop_code = DROP_STRAY;
          end
        end else begin
          go = 1'b1;
          if (cmd.first) begin
            if (fill_r != '0) begin
              out_nxt.drop_code = DROP_RESTART;
              fill_v = '0;
            end
            left_v = cmd.count;
          end else if (fill_r == '0) begin
            out_nxt.drop_code = DROP_STRAY;
            go = 1'b0;
          end else begin
            left_v = left_r - 6'd1;
            if (cmd.count != left_v) begin
              out_nxt.drop_code = DROP_MISMATCH;
              fill_v = '0;
              left_v = '0;
              go = 1'b0;
            end
          end
          // overflow check against the buffer size
          sum_v = CW'(fill_v) + CW'(cur_r);
          if (go && sum_v > MAX_C) begin
            out_nxt.drop_code = DROP_OVERFLOW;
            fill_v = '0;
            left_v = '0;
            go = 1'b0;
          end
          if (go) begin
            out_nxt.store_payload = 1'b1;
            out_nxt.write_offset  = 11'(fill_v);
            fill_v = FW'(sum_v);
            if (cmd.count == '0) begin
              out_nxt.deliver        = 1'b1;
              out_nxt.message_length = 12'(fill_v);
              out_nxt.message_type   = cmd.net_msg;
              fill_v = '0;
            end
          end
          fill_nxt = fill_v;
          left_nxt = left_v;
        end
      end
      KIND_CFG_REQ: begin
        if (!cmd.ver_ok) begin
          out_nxt.cfg_status = CST_UNSUPP;
        end else begin
          out_nxt.cfg_status = CST_OK;
          want_v = (CW'(desired_r) > MAX_C) ? MAX_C : CW'(desired_r);
          pl_v   = (NW'(want_v) < NW'(cmd.max_payload)) ? NW'(want_v) : NW'(cmd.max_payload);
          // power of two of at least the base size
          if (pl_v != '0 && (pl_v & (pl_v - NW'(1))) == '0 && pl_v >= NW'(BASE_PAYLOAD)) begin
            pend_nxt = 12'(pl_v);
            out_nxt.resp_payload_size = 12'(pl_v);
          end
          out_nxt.resp_ack_feature = ack_en_r && cmd.ack_req;
        end
      end
      KIND_XFER_ERR: begin
        fill_nxt = '0;
        left_nxt = '0;
      end
      default: begin
        cur_nxt = BASE_PAYLOAD;
      end
    endcase
    out_nxt.payload_size = cur_nxt;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      left_r      <= '0;
      cur_r       <= BASE_PAYLOAD;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd_pop) begin
      fill_r      <= fill_nxt;
      left_r      <= left_nxt;
      cur_r       <= cur_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* src/link_packet_reassembler.sv */
// channel | signals                          | moves
// input   | in_valid, in_ready, in_data      | one request: header, config, error or detach
// result  | out_valid, out_ready, out_data   | one result per request
// config  | cfg_we, cfg_index, cfg_wdata     | register write, no wait
//
// one request per cycle while out_ready stays high; a result is offered after its
// request is accepted (queue write at the accepting edge, result register on pop)
// while a result waits, up to two requests gather in the queue, then in_ready drops
// all state updates of a request happen together when the back end pops it
// reset (synchronous, active low) restores 32-byte payload and empty buffer
module link_packet_reassembler #(
  parameter int MAX_MESSAGE_BYTES = lpr_pkg::LPR_MAX_MESSAGE_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpr_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [11:0]         cfg_wdata
);
  import lpr_pkg::*;

  cmd_t      front_cmd;
  cmd_t      back_cmd;
  q_status_t q_status;
  logic      push;
  logic      pop;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // classify incoming requests
  lpr_front u_front (
    .in_item (in_data),
    .cmd     (front_cmd)
  );

  // decoupling queue
  lpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .pop_cmd  (back_cmd),
    .status   (q_status)
  );

  // reassembly and negotiation
  lpr_back #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_avail (!q_status.empty),
    .cmd       (back_cmd),
    .cmd_pop   (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // queue cannot be full and empty at once
  a_q_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty together");

  // an accepted request leaves the queue non-empty or is already in the result
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (!q_status.empty || out_valid))
    else $error("accepted request vanished");

  // no pop from an empty queue
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // payload size in use is always a power of two of at least the base size
  a_payload_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($onehot(out_data.payload_size) && out_data.payload_size >= BASE_PAYLOAD))
    else $error("bad payload size");

  // offset only given with a store
  a_offset_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.store_payload) |-> (out_data.write_offset == '0))
    else $error("offset without store");
`endif

endmodule

/* tb/link_packet_reassembler_tb.sv */
`timescale 1ns / 1ps

module link_packet_reassembler_tb;
  import lpr_pkg::*;

  localparam int NUM_PHASES   = 7;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_PRINTS   = 40;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_DESIRED_PAYLOAD;
  logic [11:0] cfg_wdata = '0;

  link_packet_reassembler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // request and result stores
  in_item_t  pending_requests[$];
  out_item_t expected_results[$];
  out_item_t oldest;
  int        queued_items = 0;
  int        result_count = 0;
  int        mismatch_count = 0;
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // shadow registers and reassembly state
  logic [11:0] desired_size;
  logic        ack_allowed;
  logic [11:0] fill_bytes;
  logic [5:0]  pkts_left;
  logic [11:0] cur_payload;
  logic [11:0] pend_payload;

  // per-phase register settings
  logic [11:0] phase_desired [NUM_PHASES] = '{12'd32, 12'd2048, 12'd256, 12'd4095,
                                             12'd100, 12'd1024, 12'd2048};
  logic        phase_ack [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5000000;
    $display("link_packet_reassembler_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  // expected result of one request; advances the shadow state
  function automatic out_item_t next_result(in_item_t it);
    out_item_t   r;
    logic [11:0] pl;
    logic [5:0]  cnt;
    logic [11:0] want;
    logic [15:0] neg;
    logic        is_dummy;
    logic        is_valid;
    logic        go;
    r = '0;
    r.ack_class = ACK_NONE;
    pl = cur_payload;
    cnt = it.header_bits[HB_COUNT_MSB:0];
    is_dummy = it.header_bits[HB_DUMMY_BIT];
    is_valid = it.header_bits[HB_VALID_BIT];
    case (it.kind)
      KIND_HEADER: begin
        if (is_valid && !is_dummy) r.ack_class = ACK_REQUIRED;
        else if (is_dummy && !is_valid) r.ack_class = ACK_DUMMY;
        else r.ack_class = ACK_GARBAGE;
        if (r.ack_class != ACK_REQUIRED) begin
          // negotiated size takes effect once the transmit side is quiet
          if (pend_payload != '0 && it.tx_queue_empty) begin
            cur_payload = pend_payload;
            pend_payload = '0;
          end
        end else if (desired_size == 12'(LPR_MAX_MESSAGE_BYTES) &&
                     pl == 12'(LPR_MAX_MESSAGE_BYTES)) begin
          // whole message in one packet
          if (it.header_bits[HB_FIRST_BIT]) begin
            r.store_payload = 1'b1;
            r.deliver = 1'b1;
            r.message_length = pl;
            r.message_type = it.header_bits[HB_TYPE_BIT];
          end else begin
            r.drop_code = DROP_STRAY;
          end
        end else begin
          go = 1'b1;
          if (it.header_bits[HB_FIRST_BIT]) begin
            if (fill_bytes != '0) begin
              r.drop_code = DROP_RESTART;
              fill_bytes = '0;
            end
            pkts_left = cnt;
          end else if (fill_bytes == '0) begin
            r.drop_code = DROP_STRAY;
            go = 1'b0;
          end else begin
            pkts_left = pkts_left - 6'd1;
            if (cnt != pkts_left) begin
              r.drop_code = DROP_MISMATCH;
              fill_bytes = '0;
              pkts_left = '0;
              go = 1'b0;
            end
          end
          if (go && int'(fill_bytes) + int'(pl) > LPR_MAX_MESSAGE_BYTES) begin
            r.drop_code = DROP_OVERFLOW;
            fill_bytes = '0;
            pkts_left = '0;
            go = 1'b0;
          end
          if (go) begin
            r.store_payload = 1'b1;
            r.write_offset = fill_bytes[10:0];
            fill_bytes = fill_bytes + pl;
            if (cnt == '0) begin
              r.deliver = 1'b1;
              r.message_length = fill_bytes;
              r.message_type = it.header_bits[HB_TYPE_BIT];
              fill_bytes = '0;
            end
          end
        end
      end
      KIND_CFG_REQ: begin
        if (it.req_version < LOWEST_VERSION) begin
          r.cfg_status = CST_UNSUPP;
        end else begin
          r.cfg_status = CST_OK;
          want = (desired_size > 12'(LPR_MAX_MESSAGE_BYTES)) ?
                 12'(LPR_MAX_MESSAGE_BYTES) : desired_size;
          neg = ({4'd0, want} < it.req_max_payload) ? {4'd0, want} : it.req_max_payload;
          // power of two and at least the base size
          if (neg != '0 && (neg & (neg - 16'd1)) == '0 && neg >= {4'd0, BASE_PAYLOAD}) begin
            pend_payload = neg[11:0];
            r.resp_payload_size = neg[11:0];
          end
          if (ack_allowed && it.req_features[0]) begin
            r.resp_ack_feature = 1'b1;
          end
        end
      end
      KIND_XFER_ERR: begin
        fill_bytes = '0;
        pkts_left = '0;
      end
      default: begin
        cur_payload = BASE_PAYLOAD;
      end
    endcase
    r.payload_size = cur_payload;
    return r;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: register writes, accepted requests, checked results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      desired_size = 12'd32;
      ack_allowed = 1'b1;
      fill_bytes = '0;
      pkts_left = '0;
      cur_payload = BASE_PAYLOAD;
      pend_payload = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DESIRED_PAYLOAD) desired_size = cfg_wdata;
        else ack_allowed = cfg_wdata[0];
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) expected_results.push_back(next_result(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending",
                                    result_count));
        end else begin
          oldest = expected_results.pop_front();
          check_field("ack_class", 16'(out_data.ack_class), 16'(oldest.ack_class));
          check_field("store_payload", 16'(out_data.store_payload),
                      16'(oldest.store_payload));
          check_field("write_offset", 16'(out_data.write_offset),
                      16'(oldest.write_offset));
          check_field("deliver", 16'(out_data.deliver), 16'(oldest.deliver));
          check_field("message_length", 16'(out_data.message_length),
                      16'(oldest.message_length));
          check_field("message_type", 16'(out_data.message_type),
                      16'(oldest.message_type));
          check_field("drop_code", 16'(out_data.drop_code), 16'(oldest.drop_code));
          check_field("payload_size", 16'(out_data.payload_size),
                      16'(oldest.payload_size));
          check_field("cfg_status", 16'(out_data.cfg_status), 16'(oldest.cfg_status));
          check_field("resp_payload_size", 16'(out_data.resp_payload_size),
                      16'(oldest.resp_payload_size));
          check_field("resp_ack_feature", 16'(out_data.resp_ack_feature),
                      16'(oldest.resp_ack_feature));
        end
        result_count++;
      end
    end
  end

  function automatic logic [9:0] header_word(logic dmy, logic fst, logic vld, logic net,
                                             logic [5:0] cnt);
    logic [9:0] h;
    h = '0;
    h[HB_DUMMY_BIT] = dmy;
    h[HB_FIRST_BIT] = fst;
    h[HB_VALID_BIT] = vld;
    h[HB_TYPE_BIT] = net;
    h[HB_COUNT_MSB:0] = cnt;
    return h;
  endfunction

  // request of the given kind with every field random
  function automatic in_item_t rand_item(kind_t k);
    in_item_t it;
    it.kind = k;
    it.header_bits = 10'($urandom_range(1023));
    it.tx_queue_empty = 1'($urandom_range(1));
    it.req_max_payload = 16'($urandom_range(65535));
    it.req_features = 8'($urandom_range(255));
    it.req_version = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    pending_requests.push_back(it);
    queued_items++;
  endtask

  task automatic push_header(logic [9:0] hb, logic txe);
    in_item_t it;
    it = rand_item(KIND_HEADER);
    it.header_bits = hb;
    it.tx_queue_empty = txe;
    push_item(it);
  endtask

  task automatic push_cfg(logic [15:0] rmax, logic [7:0] feat, logic [7:0] ver);
    in_item_t it;
    it = rand_item(KIND_CFG_REQ);
    it.req_max_payload = rmax;
    it.req_features = feat;
    it.req_version = ver;
    push_item(it);
  endtask

  task automatic push_dummy(logic txe);
    logic [9:0] hb;
    hb = 10'($urandom_range(1023));
    hb[HB_DUMMY_BIT] = 1'b1;
    hb[HB_VALID_BIT] = 1'b0;
    push_header(hb, txe);
  endtask

  task automatic apply_config(logic [11:0] size, logic ack);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DESIRED_PAYLOAD;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_index <= REG_ACK_ENABLE;
    cfg_wdata <= {11'd0, ack};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // first packet plus followers, sometimes with one flaw
  task automatic send_message();
    int unsigned n, r, flaw, flaw_at, k;
    r = $urandom_range(99);
    if (r < 65) n = $urandom_range(4);
    else if (r < 88) n = $urandom_range(5, 20);
    else if (r < 95) n = $urandom_range(21, 62);
    else n = 63;
    flaw = ($urandom_range(99) < 15) ? $urandom_range(1, 4) : 0;
    flaw_at = $urandom_range(n);
    push_header(header_word(1'b0, 1'b1, 1'b1, 1'($urandom_range(1)), 6'(n)),
                1'($urandom_range(1)));
    for (k = 1; k <= n; k++) begin
      if (flaw != 0 && k == flaw_at) begin
        case (flaw)
          1: push_header(header_word(1'b0, 1'b0, 1'b1, 1'($urandom_range(1)),
                                     6'(n - k + $urandom_range(1, 63))), 1'b1);
          2: return;
          3: push_item(rand_item(KIND_XFER_ERR));
          default: push_dummy(1'($urandom_range(1)));
        endcase
      end
      push_header(header_word(1'b0, 1'b0, 1'b1, 1'($urandom_range(1)), 6'(n - k)),
                  1'($urandom_range(1)));
    end
  endtask

  task automatic directed_checks();
    // garbage both ways, dummy with nothing pending
    push_header(header_word(1'b0, 1'b0, 1'b0, 1'b0, 6'd0), 1'b1);
    push_header(10'h3FF, 1'b0);
    push_header(header_word(1'b1, 1'b1, 1'b0, 1'b1, 6'h3F), 1'b1);
    // old partners, then accepted requests with and without ack
    push_cfg(16'hFFFF, 8'hFF, 8'd0);
    push_cfg(16'hFFFF, 8'hFF, 8'd1);
    push_cfg(16'hFFFF, 8'hFF, 8'd255);
    push_cfg(16'd16, 8'h00, 8'd2);
    // pending size held while transmit busy, applied when empty
    push_header(header_word(1'b1, 1'b0, 1'b0, 1'b0, 6'd0), 1'b0);
    push_header(header_word(1'b1, 1'b0, 1'b0, 1'b0, 6'd0), 1'b1);
    // stray follower, single packet, three-packet message
    push_header(header_word(1'b0, 1'b0, 1'b1, 1'b0, 6'd0), 1'b1);
    push_header(header_word(1'b0, 1'b1, 1'b1, 1'b1, 6'd0), 1'b1);
    push_header(header_word(1'b0, 1'b1, 1'b1, 1'b0, 6'd2), 1'b0);
    push_header(header_word(1'b0, 1'b0, 1'b1, 1'b0, 6'd1), 1'b0);
    push_header(header_word(1'b0, 1'b0, 1'b1, 1'b1, 6'd0), 1'b0);
    // restart before complete
    push_header(header_word(1'b0, 1'b1, 1'b1, 1'b0, 6'd3), 1'b1);
    push_header(header_word(1'b0, 1'b1, 1'b1, 1'b0, 6'd0), 1'b1);
    // count mismatch
    push_header(header_word(1'b0, 1'b1, 1'b1, 1'b0, 6'd2), 1'b1);
    push_header(header_word(1'b0, 1'b0, 1'b1, 1'b0, 6'd0), 1'b1);
    // transfer error mid-message leaves the follower stray
    push_header(header_word(1'b0, 1'b1, 1'b1, 1'b0, 6'd5), 1'b1);
    push_item(rand_item(KIND_XFER_ERR));
    push_header(header_word(1'b0, 1'b0, 1'b1, 1'b0, 6'd4), 1'b1);
    push_item(rand_item(KIND_DETACH));
  endtask

  task automatic random_traffic(int n);
    int target, r;
    logic [9:0] hb;
    logic [7:0] ver;
    logic [15:0] rmax;
    target = queued_items + n;
    // negotiate this phase's capped size; put it in use if a power of two of at least 32 bytes
    push_cfg(16'hFFFF, 8'($urandom_range(255)), 8'($urandom_range(2, 255)));
    push_dummy(1'b1);
    while (queued_items < target) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_message();
      end else if (r < 60) begin
        ver = ($urandom_range(99) < 85) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(1));
        r = $urandom_range(99);
        if (r < 55) rmax = 16'd1 << $urandom_range(15);
        else if (r < 70) rmax = 16'($urandom_range(2048, 65535));
        else rmax = 16'($urandom_range(65535));
        push_cfg(rmax, 8'($urandom_range(255)), ver);
      end else if (r < 75) begin
        push_dummy($urandom_range(99) < 80);
      end else if (r < 82) begin
        hb = 10'($urandom_range(1023));
        hb[HB_VALID_BIT] = hb[HB_DUMMY_BIT];
        push_header(hb, 1'($urandom_range(1)));
      end else if (r < 87) begin
        push_item(rand_item(KIND_XFER_ERR));
      end else if (r < 90) begin
        push_item(rand_item(KIND_DETACH));
      end else begin
        push_item(rand_item(kind_t'($urandom_range(3))));
      end
    end
  endtask

  // phases: register setting, idling mode, traffic, drain
  initial begin
    int p;
    wait (rst_n === 1'b1);
    @(negedge clk);
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 78;
      end else if (p < 5) begin
        send_idle_pct = 78;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_config(phase_desired[p], phase_ack[p]);
      if (p == 0) directed_checks();
      random_traffic((p == 0) ? 170 : 195);
      @(posedge clk);
      while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      @(negedge clk);
    end
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("link_packet_reassembler_tb: PASS");
    end else begin
      $display("link_packet_reassembler_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/lpr_pkg.sv
src/lpr_front.sv
src/lpr_queue.sv
src/lpr_back.sv
src/link_packet_reassembler.sv
tb/link_packet_reassembler_tb.sv
